// File: sv/rrco_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrco_pkg
// shared widths, register codes and the quarter-wave sine generator
// ----------------------------------------------------------------------------
package rrco_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int COORD_W = 20;
    localparam int SIZE_W  = 16;
    localparam int ANGLE_W = 16;
    localparam int SCALE_W = 16;
    localparam int OFFS_W  = 16;
    localparam int RAD_W   = 16;
    localparam int MAG_W   = 15;
    localparam int SINE_W  = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [1:0] {
        REG_CX     = 2'd0,
        REG_CY     = 2'd1,
        REG_RADIUS = 2'd2,
        REG_ALLOW  = 2'd3
    } t_reg_idx;

    // quarter-wave sine magnitude in q0.15, u in [0, 16384]
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [14:0] u);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(u) * PI_Q30) >> 15;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                7:       term = term / 210;
                default: term = term / 272;
            endcase
            if (k % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/rrco_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrco_in_if
// request channel: one rectangle test per beat
// ----------------------------------------------------------------------------
interface rrco_in_if;
    import rrco_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  rect_left;
    logic signed [COORD_W-1:0]  rect_top;
    logic        [SIZE_W-1:0]   rect_width;
    logic        [SIZE_W-1:0]   rect_height;
    logic        [ANGLE_W-1:0]  rotation_angle;
    logic                       target_concealed;
    logic                       item_allows_concealed;
    logic        [SCALE_W-1:0]  radius_scale;
    logic signed [OFFS_W-1:0]   radius_offset;

    modport source (
        output valid, rect_left, rect_top, rect_width, rect_height, rotation_angle,
               target_concealed, item_allows_concealed, radius_scale, radius_offset,
        input  ready
    );

    modport sink (
        input  valid, rect_left, rect_top, rect_width, rect_height, rotation_angle,
               target_concealed, item_allows_concealed, radius_scale, radius_offset,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/rrco_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrco_out_if
// result channel: one overlap flag per beat
// ----------------------------------------------------------------------------
interface rrco_out_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (
        output valid, overlaps,
        input  ready
    );

    modport sink (
        input  valid, overlaps,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/rotated_rect_circle_overlap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_rect_circle_overlap
// rotated rectangle versus fixed circle overlap test, six-stage pipeline
// ----------------------------------------------------------------------------
// One request beat gives one result beat; a new request is taken every cycle
// unless a full pipeline is held by the output. The six stages are: sine rom
// read with centre offsets and radius product, the four rotation multiplies and
// the adjusted radius, the rotated offsets and the squared radius, the clamp
// excess, the squares, and the final sum and compare into the output register.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up under back-pressure and ready drops only
// when all six stages hold data. Configuration is an APB port with four 32-bit
// registers at byte offsets 0, 4, 8 and 12; write it only while the pipeline is
// empty.
// ----------------------------------------------------------------------------
module rotated_rect_circle_overlap #(
    parameter int SINE_TABLE_BITS = rrco_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrco_pkg::APB_AW-1:0] paddr,
    input  logic [rrco_pkg::APB_DW-1:0] pwdata,
    output logic [rrco_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    rrco_in_if.sink                     i_in,
    rrco_out_if.source                  o_out
);
    import rrco_pkg::*;

    localparam int NSTG  = 6;
    localparam int DW    = 23;
    localparam int PW    = 39;
    localparam int LW    = 40;
    localparam int RADW  = 34;
    localparam int R2W   = 62;
    localparam int EXW   = 25;
    localparam int SQW   = 50;
    localparam int QTURN = 1 << (SINE_TABLE_BITS - 2);

    // configuration registers
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic        [RAD_W-1:0]   r_radius;
    logic                      r_allow;
    t_reg_idx                  w_reg;

    assign w_reg  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_radius <= '0;
            r_allow  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_CX:     r_cx     <= signed'(pwdata[COORD_W-1:0]);
                REG_CY:     r_cy     <= signed'(pwdata[COORD_W-1:0]);
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_ALLOW:  r_allow  <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_CX:     prdata = {{(APB_DW-COORD_W){1'b0}}, r_cx};
            REG_CY:     prdata = {{(APB_DW-COORD_W){1'b0}}, r_cy};
            REG_RADIUS: prdata = {{(APB_DW-RAD_W){1'b0}}, r_radius};
            REG_ALLOW:  prdata = {{(APB_DW-1){1'b0}}, r_allow};
            default:    prdata = '0;
        endcase
    end

    // stage valids and advance enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready  = w_en[0];
    assign o_out.valid = r_vld[NSTG-1];

    // stage 0: centre offsets, radius product, rom read
    logic [SINE_TABLE_BITS-1:0] w_idx_s;
    logic [SINE_TABLE_BITS-1:0] w_idx_c;
    logic signed [SINE_W-1:0]   w_sin;
    logic signed [SINE_W-1:0]   w_cos;
    logic signed [DW-1:0]       n0_dx2;
    logic signed [DW-1:0]       n0_dy2;
    logic signed [DW-1:0]       r0_dx2;
    logic signed [DW-1:0]       r0_dy2;
    logic        [SIZE_W-1:0]   r0_w;
    logic        [SIZE_W-1:0]   r0_h;
    logic        [31:0]         r0_prod;
    logic signed [OFFS_W-1:0]   r0_offs;
    logic                       r0_rej;

    assign w_idx_s = i_in.rotation_angle[ANGLE_W-1 -: SINE_TABLE_BITS];
    assign w_idx_c = w_idx_s + SINE_TABLE_BITS'(QTURN);

    rrco_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_idx_a (w_idx_s),
        .i_idx_b (w_idx_c),
        .o_sin_a (w_sin),
        .o_sin_b (w_cos)
    );

    always_comb begin
        n0_dx2 = (DW'(r_cx) <<< 1)
               - ((DW'(i_in.rect_left) <<< 1) + signed'(DW'(i_in.rect_width)));
        n0_dy2 = (DW'(r_cy) <<< 1)
               - ((DW'(i_in.rect_top) <<< 1) + signed'(DW'(i_in.rect_height)));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_dx2  <= n0_dx2;
            r0_dy2  <= n0_dy2;
            r0_w    <= i_in.rect_width;
            r0_h    <= i_in.rect_height;
            r0_prod <= 32'(r_radius) * 32'(i_in.radius_scale);
            r0_offs <= i_in.radius_offset;
            r0_rej  <= i_in.target_concealed && !(r_allow || i_in.item_allows_concealed);
        end
    end

    // stage 1: rotation products, adjusted radius
    logic signed [PW-1:0]     r1_pa;
    logic signed [PW-1:0]     r1_pb;
    logic signed [PW-1:0]     r1_pc;
    logic signed [PW-1:0]     r1_pd;
    logic signed [RADW-1:0]   r1_rad;
    logic        [SIZE_W-1:0] r1_w;
    logic        [SIZE_W-1:0] r1_h;
    logic                     r1_rej;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_pa  <= PW'(w_cos) * PW'(r0_dx2);
            r1_pb  <= PW'(w_sin) * PW'(r0_dy2);
            r1_pc  <= PW'(w_cos) * PW'(r0_dy2);
            r1_pd  <= PW'(w_sin) * PW'(r0_dx2);
            r1_rad <= signed'({2'b00, r0_prod}) + (RADW'(r0_offs) <<< 8);
            r1_w   <= r0_w;
            r1_h   <= r0_h;
            r1_rej <= r0_rej;
        end
    end

    // stage 2: rotated offsets, radius squared
    logic signed [LW-1:0]     r2_lx;
    logic signed [LW-1:0]     r2_ly;
    logic        [R2W-1:0]    r2_r2;
    logic                     r2_neg;
    logic                     r2_huge;
    logic        [SIZE_W-1:0] r2_w;
    logic        [SIZE_W-1:0] r2_h;
    logic                     r2_rej;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_lx   <= LW'(r1_pa) + LW'(r1_pb);
            r2_ly   <= LW'(r1_pc) - LW'(r1_pd);
            r2_r2   <= R2W'(r1_rad[30:0]) * R2W'(r1_rad[30:0]);
            r2_neg  <= r1_rad[RADW-1];
            r2_huge <= !r1_rad[RADW-1] && (|r1_rad[32:31]);
            r2_w    <= r1_w;
            r2_h    <= r1_h;
            r2_rej  <= r1_rej;
        end
    end

    // stage 3: excess beyond each half side, rounded to 1/2
    function automatic logic [EXW-1:0] excess(input logic signed [LW-1:0] off,
                                              input logic [SIZE_W-1:0]    half);
        logic [LW-1:0] mag;
        logic [LW-1:0] lim;
        logic [LW-1:0] d;
        mag = off[LW-1] ? unsigned'(-off) : unsigned'(off);
        lim = LW'({half, 15'b0});
        d   = mag - lim + (LW'(1) << 14);
        return (mag <= lim) ? '0 : d[EXW+14:15];
    endfunction

    logic [EXW-1:0] r3_ex;
    logic [EXW-1:0] r3_ey;
    logic [R2W-1:0] r3_r2;
    logic           r3_neg;
    logic           r3_huge;
    logic           r3_rej;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_ex   <= excess(r2_lx, r2_w);
            r3_ey   <= excess(r2_ly, r2_h);
            r3_r2   <= r2_r2;
            r3_neg  <= r2_neg;
            r3_huge <= r2_huge;
            r3_rej  <= r2_rej;
        end
    end

    // stage 4: squares
    logic [SQW-1:0] r4_ex2;
    logic [SQW-1:0] r4_ey2;
    logic [R2W-1:0] r4_r2;
    logic           r4_neg;
    logic           r4_huge;
    logic           r4_rej;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_ex2  <= SQW'(r3_ex) * SQW'(r3_ex);
            r4_ey2  <= SQW'(r3_ey) * SQW'(r3_ey);
            r4_r2   <= r3_r2;
            r4_neg  <= r3_neg;
            r4_huge <= r3_huge;
            r4_rej  <= r3_rej;
        end
    end

    // stage 5: distance compare into the output register
    logic [SQW:0]      w_dsq;
    logic [SQW+14:0]   w_dsq_s;
    logic              w_cmp;
    logic              r5_ovl;

    always_comb begin
        w_dsq   = (SQW+1)'(r4_ex2) + (SQW+1)'(r4_ey2);
        w_dsq_s = {w_dsq, 14'b0};
        w_cmp   = w_dsq_s <= (SQW+15)'(r4_r2);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_ovl <= !r4_rej && !r4_neg && (r4_huge || w_cmp);
        end
    end

    assign o_out.overlaps = r5_ovl;

`ifndef NO_ASSERTIONS
    a_rej_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && r4_rej && w_en[5] |=> !o_out.overlaps)
        else $error("concealed target reported as overlap");

    a_huge_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && r4_huge && !r4_rej && w_en[5] |=> o_out.overlaps)
        else $error("huge radius not reported as overlap");

    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_vld) && !o_out.ready)
        else $error("request stalled with a bubble in the pipeline");
`endif

endmodule
`default_nettype wire

// File: sv/rrco_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrco_sine_rom
// dual-read quarter-wave sine rom with registered read, q1.15 signed output
// ----------------------------------------------------------------------------
module rrco_sine_rom #(
    parameter int SINE_TABLE_BITS = rrco_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic        [SINE_TABLE_BITS-1:0]  i_idx_a,
    input  logic        [SINE_TABLE_BITS-1:0]  i_idx_b,
    output logic signed [rrco_pkg::SINE_W-1:0] o_sin_a,
    output logic signed [rrco_pkg::SINE_W-1:0] o_sin_b
);
    import rrco_pkg::*;

    localparam int UW      = SINE_TABLE_BITS - 1;
    localparam int QDEPTH  = 1 << (SINE_TABLE_BITS - 2);
    localparam int PSHIFT  = 16 - SINE_TABLE_BITS;

    logic [MAG_W-1:0] w_tab [QDEPTH+1];

    for (genvar j = 0; j <= QDEPTH; j++) begin : g_tab
        assign w_tab[j] = quarter_sine(15'(j << PSHIFT));
    end

    logic [UW-1:0]    w_u_a;
    logic [UW-1:0]    w_u_b;
    logic [MAG_W-1:0] r_mag_a;
    logic [MAG_W-1:0] r_mag_b;
    logic             r_neg_a;
    logic             r_neg_b;

    // fold onto the quarter wave
    always_comb begin
        w_u_a = i_idx_a[SINE_TABLE_BITS-2] ?
                (UW'(QDEPTH) - {1'b0, i_idx_a[SINE_TABLE_BITS-3:0]}) :
                {1'b0, i_idx_a[SINE_TABLE_BITS-3:0]};
        w_u_b = i_idx_b[SINE_TABLE_BITS-2] ?
                (UW'(QDEPTH) - {1'b0, i_idx_b[SINE_TABLE_BITS-3:0]}) :
                {1'b0, i_idx_b[SINE_TABLE_BITS-3:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_a <= w_tab[w_u_a];
            r_mag_b <= w_tab[w_u_b];
            r_neg_a <= i_idx_a[SINE_TABLE_BITS-1];
            r_neg_b <= i_idx_b[SINE_TABLE_BITS-1];
        end
    end

    assign o_sin_a = r_neg_a ? -signed'({1'b0, r_mag_a}) : signed'({1'b0, r_mag_a});
    assign o_sin_b = r_neg_b ? -signed'({1'b0, r_mag_b}) : signed'({1'b0, r_mag_b});

endmodule
`default_nettype wire

// File: sim/rotated_rect_circle_overlap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rect_circle_overlap_tb
// Self-checking bench for the rotated rectangle versus circle overlap test.
// A bit-exact predictor turns the circle centre into each rectangle's frame
// with its own quarter-wave sine, clamps, and compares squared distances.
// Directed tests cover field extremes, every quarter turn, degenerate
// rectangles, concealment and the radius corner cases. A back-pressure test
// fills the pipeline. Random phases with fresh circle settings follow.
// Each result beat is checked in order against the predicted flag.
// ----------------------------------------------------------------------------
module rotated_rect_circle_overlap_tb;
    import rrco_pkg::*;

    localparam int          SINE_BITS  = 10;
    localparam int          PIPE_DEPTH = 6;
    localparam longint unsigned PI_FIXED = 64'd3373259426;

    typedef struct {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
        logic        [ANGLE_W-1:0] angle;
        logic                      concealed;
        logic                      item_ok;
        logic        [SCALE_W-1:0] scale;
        logic signed [OFFS_W-1:0]  offset;
    } t_rect_req;

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [RAD_W-1:0]   radius;
        logic                      allow;
    } t_circle_cfg;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rrco_in_if  in_if ();
    rrco_out_if out_if ();

    rotated_rect_circle_overlap #(
        .SINE_TABLE_BITS(SINE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_circle_cfg circle;
    bit          overlap_q[$];
    int          mismatches   = 0;
    int          results_seen = 0;
    bit          src_gaps     = 1'b1;
    bit          snk_gaps     = 1'b1;
    int          sink_hold    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sine in q1.15 of a 16-bit phase, quarter wave by taylor series
    function automatic longint sin_turn(longint unsigned phase);
        longint unsigned p, quad, rr, u, x, t, v;
        longint          s;
        p    = phase & 64'hFFFF;
        quad = (p >> 14) & 64'd3;
        rr   = p & 64'h3FFF;
        u    = quad[0] ? (64'd16384 - rr) : rr;
        x    = (u * PI_FIXED) >> 15;
        t    = x;
        s    = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                s = s - longint'(t);
            end else begin
                s = s + longint'(t);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        v = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return (quad >= 2) ? -longint'(v) : longint'(v);
    endfunction

    // distance beyond the half side, rounded to 1/2 units
    function automatic longint unsigned clamp_excess(longint off, longint unsigned half);
        longint unsigned mag, lim;
        mag = (off < 0) ? longint'(-off) : longint'(off);
        lim = half << 15;
        if (mag <= lim) begin
            return 0;
        end
        return (mag - lim + (64'd1 << 14)) >> 15;
    endfunction

    function automatic bit predict_overlap(t_rect_req r, t_circle_cfg c);
        longint          dx2, dy2, lx, ly, sn, cs, rad;
        longint unsigned ph, ex, ey, dsq, r2;
        if (r.concealed && !(c.allow || r.item_ok)) begin
            return 1'b0;
        end
        ph  = longint'(r.angle >> (16 - SINE_BITS)) << (16 - SINE_BITS);
        sn  = sin_turn(ph);
        cs  = sin_turn(ph + 64'd16384);
        dx2 = 2 * longint'(c.cx) - (2 * longint'(r.left) + longint'(r.width));
        dy2 = 2 * longint'(c.cy) - (2 * longint'(r.top) + longint'(r.height));
        lx  = cs * dx2 + sn * dy2;
        ly  = cs * dy2 - sn * dx2;
        ex  = clamp_excess(lx, longint'(r.width));
        ey  = clamp_excess(ly, longint'(r.height));
        dsq = ex * ex + ey * ey;
        rad = longint'(c.radius) * longint'(r.scale) + longint'(r.offset) * 256;
        if (rad < 0) begin
            return 1'b0;
        end
        if (rad >= (64'sd1 << 31)) begin
            return 1'b1;
        end
        r2 = longint'(rad) * longint'(rad);
        return (dsq << 14) <= r2;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // result checking and request capture
    always @(posedge i_clk) begin : scoreboard
        t_rect_req seen;
        bit        want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (overlap_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with no request pending",
                                              results_seen));
                end else begin
                    want = overlap_q.pop_front();
                    if (out_if.overlaps !== want) begin
                        report_mismatch($sformatf("result beat %0d: overlaps %b, expected %b",
                                                  results_seen, out_if.overlaps, want));
                    end
                end
                results_seen++;
            end
            if (in_if.valid && in_if.ready) begin
                seen.left      = in_if.rect_left;
                seen.top       = in_if.rect_top;
                seen.width     = in_if.rect_width;
                seen.height    = in_if.rect_height;
                seen.angle     = in_if.rotation_angle;
                seen.concealed = in_if.target_concealed;
                seen.item_ok   = in_if.item_allows_concealed;
                seen.scale     = in_if.radius_scale;
                seen.offset    = in_if.radius_offset;
                overlap_q.push_back(predict_overlap(seen, circle));
            end
        end
    end

    // result side: random stalls, plus a long hold when asked
    initial begin : result_sink
        int n;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                n         = sink_hold;
                sink_hold = 0;
            end else begin
                n = snk_gaps ? $urandom_range(0, 3) : 0;
            end
            if (n > 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    task automatic apb_write(t_reg_idx idx, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CX:     circle.cx     = data[COORD_W-1:0];
            REG_CY:     circle.cy     = data[COORD_W-1:0];
            REG_RADIUS: circle.radius = data[RAD_W-1:0];
            REG_ALLOW:  circle.allow  = data[0];
        endcase
    endtask

    task automatic load_circle(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                               logic [RAD_W-1:0] radius, logic allow);
        apb_write(REG_CX, APB_DW'(cx));
        apb_write(REG_CY, APB_DW'(cy));
        apb_write(REG_RADIUS, APB_DW'(radius));
        apb_write(REG_ALLOW, APB_DW'(allow));
    endtask

    task automatic send_rect(t_rect_req r);
        int gap;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid                 <= 1'b1;
        in_if.rect_left             <= r.left;
        in_if.rect_top              <= r.top;
        in_if.rect_width            <= r.width;
        in_if.rect_height           <= r.height;
        in_if.rotation_angle        <= r.angle;
        in_if.target_concealed      <= r.concealed;
        in_if.item_allows_concealed <= r.item_ok;
        in_if.radius_scale          <= r.scale;
        in_if.radius_offset         <= r.offset;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // stop offering, wait for every pending result, then let the pipe settle
    task automatic drain_results();
        int guard;
        in_if.valid <= 1'b0;
        guard = 0;
        while (overlap_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (overlap_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", overlap_q.size()));
            overlap_q.delete();
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    function automatic t_rect_req mk_rect(int left, int top, int w, int h, int ang,
                                          bit conc, bit iok, int scale, int offs);
        t_rect_req r;
        r.left      = left[COORD_W-1:0];
        r.top       = top[COORD_W-1:0];
        r.width     = w[SIZE_W-1:0];
        r.height    = h[SIZE_W-1:0];
        r.angle     = ang[ANGLE_W-1:0];
        r.concealed = conc;
        r.item_ok   = iok;
        r.scale     = scale[SCALE_W-1:0];
        r.offset    = offs[OFFS_W-1:0];
        return r;
    endfunction

    // mostly rectangles around the circle, some anywhere
    function automatic t_rect_req rand_rect();
        t_rect_req r;
        int        w, h, span, px, py;
        if ($urandom_range(0, 9) < 2) begin
            r.left      = COORD_W'($urandom);
            r.top       = COORD_W'($urandom);
            r.width     = SIZE_W'($urandom);
            r.height    = SIZE_W'($urandom);
            r.angle     = ANGLE_W'($urandom);
            r.concealed = 1'($urandom_range(0, 1));
            r.item_ok   = 1'($urandom_range(0, 1));
            r.scale     = SCALE_W'($urandom);
            r.offset    = OFFS_W'($urandom);
            return r;
        end
        w    = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 65535))
                                             : int'($urandom_range(0, 1023));
        h    = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 65535))
                                             : int'($urandom_range(0, 1023));
        span = w + h + 2 * int'(circle.radius) + 16;
        px   = int'(circle.cx) - w / 2 + int'($urandom_range(0, 2 * span)) - span;
        py   = int'(circle.cy) - h / 2 + int'($urandom_range(0, 2 * span)) - span;
        r = mk_rect(px, py, w, h, int'($urandom_range(0, 65535)),
                    $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(128, 512)),
                    ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(0, 64)) - 32);
        return r;
    endfunction

    function automatic logic [RAD_W-1:0] rand_radius();
        return ($urandom_range(0, 7) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 2047));
    endfunction

    // circle at the origin with zero radius and concealment off
    task automatic test_reset_state();
        send_rect(mk_rect(-16, -16, 32, 32, 0, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(16, 16, 32, 32, 0, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(-16, -16, 32, 32, 0, 1'b1, 1'b0, 256, 0));
        drain_results();
    endtask

    task automatic test_directed();
        load_circle(20'sh00100, -20'sh00080, 16'h0050, 1'b0);
        send_rect(mk_rect(224, -160, 64, 64, 0, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(384, -136, 512, 16, 16384, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(384, -136, 512, 16, 32768, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(384, -136, 512, 16, 49152, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(384, -136, 512, 16, 65535, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(384, -136, 512, 16, 8192, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(524287, 524287, 65535, 65535, 65535, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(-524288, -524288, 0, 0, 0, 1'b0, 1'b0, 256, 0));
        // segment shapes
        send_rect(mk_rect(256, -256, 0, 256, 0, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(128, -56, 256, 0, 0, 1'b0, 1'b0, 256, 0));
        // edge just at the radius and just past it
        send_rect(mk_rect(336, -160, 64, 64, 0, 1'b0, 1'b0, 256, 0));
        send_rect(mk_rect(337, -160, 64, 64, 0, 1'b0, 1'b0, 256, 0));
        // concealment
        send_rect(mk_rect(224, -160, 64, 64, 0, 1'b1, 1'b0, 256, 0));
        send_rect(mk_rect(224, -160, 64, 64, 0, 1'b1, 1'b1, 256, 0));
        // negative and zero adjusted radius
        send_rect(mk_rect(224, -160, 64, 64, 0, 1'b0, 1'b0, 0, -1));
        send_rect(mk_rect(224, -160, 64, 64, 0, 1'b0, 1'b0, 65535, -32768));
        send_rect(mk_rect(224, -160, 64, 64, 0, 1'b0, 1'b0, 0, 0));
        send_rect(mk_rect(2000, 2000, 64, 64, 4096, 1'b0, 1'b0, 65535, 32767));
        send_rect(mk_rect(-1, -1, 65535, 65535, 65535, 1'b1, 1'b1, 65535, -1));
        drain_results();
        // huge radius reaches everywhere, register lets concealed targets through
        load_circle(-20'sh80000, 20'sh7FFFF, 16'hFFFF, 1'b1);
        send_rect(mk_rect(524287, -524288, 0, 0, 12345, 1'b0, 1'b0, 65535, 0));
        send_rect(mk_rect(0, 0, 16, 16, 40000, 1'b1, 1'b0, 256, 0));
        send_rect(mk_rect(-524288, 524200, 64, 64, 0, 1'b1, 1'b0, 256, 0));
        drain_results();
    endtask

    task automatic test_register_extremes();
        load_circle(-20'sh80000, 20'sh7FFFF, 16'hFFFF, 1'b1);
        repeat (20) send_rect(rand_rect());
        drain_results();
        load_circle(20'sh7FFFF, -20'sh80000, 16'h0000, 1'b0);
        repeat (20) send_rect(rand_rect());
        drain_results();
        load_circle(20'sh00000, -20'sh00001, 16'h0001, 1'b1);
        repeat (20) send_rect(rand_rect());
        drain_results();
    endtask

    // receiver holds off while requests keep coming, so the pipe fills
    task automatic test_backpressure();
        load_circle(20'sh01234, -20'sh00567, 16'h0200, 1'b0);
        src_gaps  = 1'b0;
        snk_gaps  = 1'b0;
        sink_hold = 60;
        repeat (40) send_rect(rand_rect());
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 8; ph++) begin
            load_circle(COORD_W'($urandom), COORD_W'($urandom), rand_radius(),
                        1'($urandom_range(0, 1)));
            src_gaps = ph[0];
            snk_gaps = ph[1];
            repeat (200) send_rect(rand_rect());
            drain_results();
        end
    endtask

    initial begin
        i_rst_n                     <= 1'b0;
        psel                        <= 1'b0;
        penable                     <= 1'b0;
        pwrite                      <= 1'b0;
        paddr                       <= '0;
        pwdata                      <= '0;
        in_if.valid                 <= 1'b0;
        in_if.rect_left             <= '0;
        in_if.rect_top              <= '0;
        in_if.rect_width            <= '0;
        in_if.rect_height           <= '0;
        in_if.rotation_angle        <= '0;
        in_if.target_concealed      <= 1'b0;
        in_if.item_allows_concealed <= 1'b0;
        in_if.radius_scale          <= '0;
        in_if.radius_offset         <= '0;
        circle = '{cx: '0, cy: '0, radius: '0, allow: 1'b0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        drain_results();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
